// ===== design/i2c_eeprom_transfer_sequencer_macros.svh =====
// Assertion helpers used by the sequencer top module.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define I2CEE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cee: same-cycle check failed");

// Next-cycle implication.
`define I2CEE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cee: next-cycle check failed");

`endif

// ===== design/i2cee_pkg.sv =====
`timescale 1ns / 1ps

package i2cee_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 256;
  localparam int unsigned BLOCK_BITS_DEFAULT   = 3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_EVENT = 2'd3
  } kind_e;

  localparam logic [1:0] START_NONE     = 2'd0;
  localparam logic [1:0] START_ACCEPTED = 2'd1;
  localparam logic [1:0] START_BUSY     = 2'd2;

  // Bit positions in the controller status word.
  localparam int unsigned FLAG_SB   = 0;
  localparam int unsigned FLAG_ADDR = 1;
  localparam int unsigned FLAG_BTF  = 2;
  localparam int unsigned FLAG_RXNE = 6;
  localparam int unsigned FLAG_TXE  = 7;
  localparam int unsigned FLAG_NACK = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dev_addr;
    logic [10:0] mem_addr;
    logic [8:0]  length;
    logic        bus_busy;
    logic [10:0] status_flags;
    logic [7:0]  data_byte;
    logic [7:0]  load_index;
  } item_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_byte;
    logic       start_cond;
    logic       stop_cond;
    logic       ack_level;
    logic       clear_nack;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [7:0] read_index;
    logic       done_res;
    logic [1:0] start_status;
    logic       active;
  } result_t;

endpackage

// ===== design/i2cee_in_if.sv =====
`timescale 1ns / 1ps

interface i2cee_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  dev_addr;
  logic [10:0] mem_addr;
  logic [8:0]  length;
  logic        bus_busy;
  logic [10:0] status_flags;
  logic [7:0]  data_byte;
  logic [7:0]  load_index;

  modport source (
    output valid, kind, dev_addr, mem_addr, length, bus_busy, status_flags, data_byte,
           load_index,
    input  ready
  );

  modport sink (
    input  valid, kind, dev_addr, mem_addr, length, bus_busy, status_flags, data_byte,
           load_index,
    output ready
  );
endinterface

// ===== design/i2cee_out_if.sv =====
`timescale 1ns / 1ps

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] write_byte;
  logic       start_cond;
  logic       stop_cond;
  logic       ack_level;
  logic       clear_nack;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [7:0] read_index;
  logic       done_res;
  logic [1:0] start_status;
  logic       active;

  modport source (
    output valid, write_valid, write_byte, start_cond, stop_cond, ack_level, clear_nack,
           read_valid, read_byte, read_index, done_res, start_status, active,
    input  ready
  );

  modport sink (
    input  valid, write_valid, write_byte, start_cond, stop_cond, ack_level, clear_nack,
           read_valid, read_byte, read_index, done_res, start_status, active,
    output ready
  );
endinterface

// ===== design/i2cee_ram.sv =====
`timescale 1ns / 1ps

module i2cee_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/i2cee_core.sv =====
`timescale 1ns / 1ps

module i2cee_core #(
  parameter int unsigned BUFFER_DEPTH = i2cee_pkg::BUFFER_DEPTH_DEFAULT,
  parameter int unsigned BLOCK_BITS   = i2cee_pkg::BLOCK_BITS_DEFAULT,
  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cee_pkg::item_t  item_i,
  input  logic [7:0]        tx_data_i,
  output logic [AW-1:0]     tx_raddr_o,
  output i2cee_pkg::result_t result_o
);
  import i2cee_pkg::*;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_R_START = 11'b000_0000_0010,
    PH_R_WADDR = 11'b000_0000_0100,
    PH_R_WORD  = 11'b000_0000_1000,
    PH_R_RSTRT = 11'b000_0001_0000,
    PH_R_MODE  = 11'b000_0010_0000,
    PH_R_DATA  = 11'b000_0100_0000,
    PH_T_START = 11'b000_1000_0000,
    PH_T_ADDR  = 11'b001_0000_0000,
    PH_T_DATA  = 11'b010_0000_0000,
    PH_T_LAST  = 11'b100_0000_0000
  } phase_e;

  localparam logic [2:0]    BlockMask = 3'((1 << BLOCK_BITS) - 1);
  localparam logic [AW-1:0] PtrLast   = AW'(BUFFER_DEPTH - 1);

  phase_e      phase_q, phase_d;
  logic [8:0]  byte_count_q, byte_count_d;
  logic [8:0]  xfer_length_q, xfer_length_d;
  logic [7:0]  device_byte_q, device_byte_d;
  logic [10:0] word_address_q, word_address_d;
  logic        ack_enabled_q, ack_enabled_d;
  logic [AW-1:0] tx_ptr_q, tx_ptr_d;

  logic [7:0] addr_block;
  logic [8:0] eff_length;
  logic       last_read;

  // Device address with block bits folded in, direction bit cleared for write.
  assign addr_block = {device_byte_q[7:4], device_byte_q[3:1] | (word_address_q[10:8] & BlockMask),
                       1'b0};
  assign eff_length = (xfer_length_q == 9'd0) ? 9'd1 : xfer_length_q;
  assign last_read  = !(({1'b0, byte_count_q} + 10'd1) < {1'b0, eff_length});

  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    xfer_length_d  = xfer_length_q;
    device_byte_d  = device_byte_q;
    word_address_d = word_address_q;
    ack_enabled_d  = ack_enabled_q;
    tx_ptr_d       = tx_ptr_q;
    result_o       = '0;

    if (step_i) begin
      case (kind_e'(item_i.kind))
        KIND_LOAD: begin
          // Buffer writes happen at acceptance in the top level.
        end
        KIND_READ, KIND_WRITE: begin
          if (item_i.bus_busy || (phase_q != PH_IDLE)) begin
            result_o.start_status = START_BUSY;
          end else begin
            result_o.start_status = START_ACCEPTED;
            result_o.start_cond   = 1'b1;
            byte_count_d          = '0;
            tx_ptr_d              = '0;
            xfer_length_d         = item_i.length;
            device_byte_d         = item_i.dev_addr;
            word_address_d        = item_i.mem_addr;
            if (kind_e'(item_i.kind) == KIND_READ) begin
              ack_enabled_d = 1'b1;
              phase_d       = PH_R_START;
            end else begin
              phase_d = PH_T_START;
            end
          end
        end
        KIND_EVENT: begin
          case (phase_q)
            PH_IDLE: begin
            end
            PH_R_START, PH_T_START: begin
              if (item_i.status_flags[FLAG_SB]) begin
                result_o.write_valid = 1'b1;
                result_o.write_byte  = addr_block;
                phase_d = (phase_q == PH_R_START) ? PH_R_WADDR : PH_T_ADDR;
              end
            end
            PH_R_WADDR: begin
              if (item_i.status_flags[FLAG_ADDR]) begin
                result_o.write_valid = 1'b1;
                result_o.write_byte  = word_address_q[7:0];
                phase_d              = PH_R_WORD;
              end
            end
            PH_R_WORD: begin
              if (item_i.status_flags[FLAG_TXE]) begin
                result_o.start_cond = 1'b1;
                phase_d             = PH_R_RSTRT;
              end
            end
            PH_R_RSTRT: begin
              if (item_i.status_flags[FLAG_SB]) begin
                result_o.write_valid = 1'b1;
                result_o.write_byte  = device_byte_q | 8'h01;
                phase_d              = PH_R_MODE;
              end
            end
            PH_R_MODE: begin
              if (item_i.status_flags[FLAG_ADDR]) begin
                phase_d = PH_R_DATA;
              end
            end
            PH_R_DATA: begin
              if (item_i.status_flags[FLAG_RXNE]) begin
                result_o.read_valid = 1'b1;
                result_o.read_byte  = item_i.data_byte;
                result_o.read_index = byte_count_q[7:0];
                byte_count_d        = byte_count_q + 9'd1;
                if (last_read) begin
                  ack_enabled_d      = 1'b0;
                  result_o.stop_cond = 1'b1;
                  result_o.done_res  = 1'b1;
                  phase_d            = PH_IDLE;
                end
              end
            end
            PH_T_ADDR: begin
              // A NACK means the device is still busy: clear it and poll again.
              if (item_i.status_flags[FLAG_NACK]) begin
                result_o.clear_nack = 1'b1;
                result_o.start_cond = 1'b1;
                phase_d             = PH_T_START;
              end else if (item_i.status_flags[FLAG_ADDR]) begin
                result_o.write_valid = 1'b1;
                result_o.write_byte  = word_address_q[7:0];
                phase_d              = PH_T_DATA;
              end
            end
            PH_T_DATA: begin
              if (item_i.status_flags[FLAG_TXE]) begin
                if (byte_count_q < xfer_length_q) begin
                  result_o.write_valid = 1'b1;
                  result_o.write_byte  = tx_data_i;
                  byte_count_d         = byte_count_q + 9'd1;
                  tx_ptr_d             = (tx_ptr_q == PtrLast) ? '0 : tx_ptr_q + AW'(1);
                end else begin
                  phase_d = PH_T_LAST;
                end
              end
            end
            PH_T_LAST: begin
              if (item_i.status_flags[FLAG_BTF]) begin
                result_o.stop_cond = 1'b1;
                result_o.done_res  = 1'b1;
                phase_d            = PH_IDLE;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    result_o.ack_level = ack_enabled_d;
    result_o.active    = (phase_d != PH_IDLE);
  end

  // The buffer is read one step ahead, at the position the next item will use.
  assign tx_raddr_o = tx_ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      byte_count_q   <= '0;
      xfer_length_q  <= '0;
      device_byte_q  <= '0;
      word_address_q <= '0;
      ack_enabled_q  <= 1'b1;
      tx_ptr_q       <= '0;
    end else begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      xfer_length_q  <= xfer_length_d;
      device_byte_q  <= device_byte_d;
      word_address_q <= word_address_d;
      ack_enabled_q  <= ack_enabled_d;
      tx_ptr_q       <= tx_ptr_d;
    end
  end

endmodule

// ===== design/i2c_eeprom_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// I2C EEPROM transfer sequencer.
// Input channel in_i carries one word per command: a transmit buffer load, a
// read start, a write start, or a controller status event. Output channel out_o
// returns exactly one result word per input word, in order, telling the bus
// controller what to do (byte to write, start, stop, ack level, nack clear) and
// reporting received bytes, start status and transaction completion.
// A word accepted from in_i is held in the input register; its result is loaded
// into the result register when the core steps it, which waits while the result
// register holds an unread word. Throughput: one word per cycle while out_o.ready is high.
// Transmit bytes live in a buffer RAM with a registered read port; the read for
// a data byte is issued when the event word is accepted, so the byte is ready when that word steps.
// Reset returns the sequencer to idle with the ack enabled and all counters
// cleared; buffer contents are undefined until loaded.
// When the receiver stalls, the result register holds its word, the input
// register holds the next one, and in_i.ready drops until out_o.ready returns.
`include "i2c_eeprom_transfer_sequencer_macros.svh"

module i2c_eeprom_transfer_sequencer #(
  parameter int unsigned BUFFER_DEPTH = i2cee_pkg::BUFFER_DEPTH_DEFAULT,
  parameter int unsigned BLOCK_BITS   = i2cee_pkg::BLOCK_BITS_DEFAULT
) (
  input logic            clk_i,
  input logic            rst_ni,
  i2cee_in_if.sink       in_i,
  i2cee_out_if.source    out_o
);
  import i2cee_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic          in_accept;
  logic          s1_valid_q;
  item_t         s1_item_q;
  logic          s1_adv;
  logic          out_valid_q;
  result_t       result_q;
  result_t       step_result;
  logic [AW-1:0] tx_raddr;
  logic [7:0]    tx_rdata;
  logic          buf_we;
  logic          out_refused;
  logic          out_done;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_accept  = in_i.valid && in_i.ready;

  // Loads go straight into the buffer; indexes past its end are dropped.
  assign buf_we = in_accept && (kind_e'(in_i.kind) == KIND_LOAD)
                  && (32'(in_i.load_index) < BUFFER_DEPTH);

  i2cee_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_tx_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (AW'(in_i.load_index)),
    .wdata_i (in_i.data_byte),
    .re_i    (in_accept),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  i2cee_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .BLOCK_BITS   (BLOCK_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_adv),
    .item_i     (s1_item_q),
    .tx_data_i  (tx_rdata),
    .tx_raddr_o (tx_raddr),
    .result_o   (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.kind         <= in_i.kind;
      s1_item_q.dev_addr     <= in_i.dev_addr;
      s1_item_q.mem_addr     <= in_i.mem_addr;
      s1_item_q.length       <= in_i.length;
      s1_item_q.bus_busy     <= in_i.bus_busy;
      s1_item_q.status_flags <= in_i.status_flags;
      s1_item_q.data_byte    <= in_i.data_byte;
      s1_item_q.load_index   <= in_i.load_index;
    end
    if (s1_adv) begin
      result_q <= step_result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.write_valid  = result_q.write_valid;
  assign out_o.write_byte   = result_q.write_byte;
  assign out_o.start_cond   = result_q.start_cond;
  assign out_o.stop_cond    = result_q.stop_cond;
  assign out_o.ack_level    = result_q.ack_level;
  assign out_o.clear_nack   = result_q.clear_nack;
  assign out_o.read_valid   = result_q.read_valid;
  assign out_o.read_byte    = result_q.read_byte;
  assign out_o.read_index   = result_q.read_index;
  assign out_o.done_res     = result_q.done_res;
  assign out_o.start_status = result_q.start_status;
  assign out_o.active       = result_q.active;

  assign out_refused = out_valid_q && (result_q.start_status == START_BUSY);
  assign out_done    = out_valid_q && result_q.done_res;

  `I2CEE_ASSERT_NEXT(a_step_fills_output, s1_adv, out_valid_q)
  `I2CEE_ASSERT_IMPL(a_refused_no_start, out_refused, !result_q.start_cond)
  `I2CEE_ASSERT_IMPL(a_done_stops_idle, out_done, result_q.stop_cond && !result_q.active)
  `I2CEE_ASSERT_IMPL(a_one_direction, out_valid_q, !(result_q.read_valid && result_q.write_valid))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import i2cee_pkg::*;

  localparam int unsigned ITEM_BUDGET   = 650;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [10:0] SB_BIT   = 11'(1) << FLAG_SB;
  localparam logic [10:0] ADDR_BIT = 11'(1) << FLAG_ADDR;
  localparam logic [10:0] BTF_BIT  = 11'(1) << FLAG_BTF;
  localparam logic [10:0] RXNE_BIT = 11'(1) << FLAG_RXNE;
  localparam logic [10:0] TXE_BIT  = 11'(1) << FLAG_TXE;
  localparam logic [10:0] NACK_BIT = 11'(1) << FLAG_NACK;

  typedef enum logic [3:0] {
    SEQ_IDLE   = 4'd0,
    RD_START   = 4'd1,
    RD_DEV_W   = 4'd2,
    RD_WORD    = 4'd3,
    RD_RESTART = 4'd4,
    RD_DEV_R   = 4'd5,
    RD_DATA    = 4'd6,
    WR_START   = 4'd7,
    WR_ADDR    = 4'd8,
    WR_DATA    = 4'd9,
    WR_LAST    = 4'd10
  } seq_phase_e;

  logic clk_i;
  logic rst_ni;

  i2cee_in_if  in_if ();
  i2cee_out_if out_if ();

  i2c_eeprom_transfer_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted sequencer state, advanced as each word is accepted.
  seq_phase_e  seq_phase = SEQ_IDLE;
  logic [8:0]  byte_cnt = '0;
  logic [8:0]  xfer_len = '0;
  logic [7:0]  dev_reg = '0;
  logic [10:0] word_addr = '0;
  logic        ack_en = 1'b1;
  logic [7:0]  tx_buf [256];
  bit          tx_known [256];

  result_t     expected_results [$];
  int unsigned mismatches = 0;
  int unsigned sent_words = 0;
  int unsigned hold_req = 0;
  bit          sender_gaps = 1'b0;
  int unsigned burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] dev_with_block();
    logic [7:0] blk;
    blk = 8'((word_addr >> 8) & ((1 << BLOCK_BITS_DEFAULT) - 1));
    return (dev_reg | (blk << 1)) & 8'hFE;
  endfunction

  function automatic result_t predict_step(input item_t w);
    result_t    r;
    logic [9:0] eff;
    r = '0;
    case (kind_e'(w.kind))
      KIND_LOAD: begin
        tx_buf[w.load_index] = w.data_byte;
        tx_known[w.load_index] = 1'b1;
      end
      KIND_READ, KIND_WRITE: begin
        if (w.bus_busy || seq_phase != SEQ_IDLE) begin
          r.start_status = START_BUSY;
        end else begin
          r.start_status = START_ACCEPTED;
          r.start_cond = 1'b1;
          byte_cnt = '0;
          xfer_len = w.length;
          dev_reg = w.dev_addr;
          word_addr = w.mem_addr;
          if (kind_e'(w.kind) == KIND_READ) begin
            ack_en = 1'b1;
            seq_phase = RD_START;
          end else begin
            seq_phase = WR_START;
          end
        end
      end
      default: begin
        case (seq_phase)
          RD_START, WR_START: begin
            if (w.status_flags[FLAG_SB]) begin
              r.write_valid = 1'b1;
              r.write_byte = dev_with_block();
              seq_phase = (seq_phase == RD_START) ? RD_DEV_W : WR_ADDR;
            end
          end
          RD_DEV_W: begin
            if (w.status_flags[FLAG_ADDR]) begin
              r.write_valid = 1'b1;
              r.write_byte = word_addr[7:0];
              seq_phase = RD_WORD;
            end
          end
          RD_WORD: begin
            if (w.status_flags[FLAG_TXE]) begin
              r.start_cond = 1'b1;
              seq_phase = RD_RESTART;
            end
          end
          RD_RESTART: begin
            if (w.status_flags[FLAG_SB]) begin
              r.write_valid = 1'b1;
              r.write_byte = dev_reg | 8'h01;
              seq_phase = RD_DEV_R;
            end
          end
          RD_DEV_R: begin
            if (w.status_flags[FLAG_ADDR]) seq_phase = RD_DATA;
          end
          RD_DATA: begin
            if (w.status_flags[FLAG_RXNE]) begin
              // A zero length still reads one byte.
              eff = (xfer_len == '0) ? 10'd1 : {1'b0, xfer_len};
              r.read_valid = 1'b1;
              r.read_byte = w.data_byte;
              r.read_index = byte_cnt[7:0];
              if ({1'b0, byte_cnt} + 10'd1 >= eff) begin
                ack_en = 1'b0;
                r.stop_cond = 1'b1;
                r.done_res = 1'b1;
                seq_phase = SEQ_IDLE;
              end
              byte_cnt = byte_cnt + 9'd1;
            end
          end
          WR_ADDR: begin
            // A nack wins over an address ack and restarts for ack polling.
            if (w.status_flags[FLAG_NACK]) begin
              r.clear_nack = 1'b1;
              r.start_cond = 1'b1;
              seq_phase = WR_START;
            end else if (w.status_flags[FLAG_ADDR]) begin
              r.write_valid = 1'b1;
              r.write_byte = word_addr[7:0];
              seq_phase = WR_DATA;
            end
          end
          WR_DATA: begin
            if (w.status_flags[FLAG_TXE]) begin
              if (byte_cnt < xfer_len) begin
                r.write_valid = 1'b1;
                r.write_byte = tx_buf[byte_cnt[7:0]];
                byte_cnt = byte_cnt + 9'd1;
              end else begin
                seq_phase = WR_LAST;
              end
            end
          end
          WR_LAST: begin
            if (w.status_flags[FLAG_BTF]) begin
              r.stop_cond = 1'b1;
              r.done_res = 1'b1;
              seq_phase = SEQ_IDLE;
            end
          end
          default: ;
        endcase
      end
    endcase
    r.ack_level = ack_en;
    r.active = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  function automatic item_t rand_fields();
    logic [63:0] bits;
    item_t       w;
    bits = {$urandom, $urandom};
    w = bits[57:0];
    return w;
  endfunction

  function automatic item_t mk_load(input logic [7:0] idx, input logic [7:0] data);
    item_t w;
    w = rand_fields();
    w.kind = KIND_LOAD;
    w.load_index = idx;
    w.data_byte = data;
    return w;
  endfunction

  function automatic item_t mk_start(input kind_e k, input logic [7:0] dev,
                                     input logic [10:0] maddr, input logic [8:0] len,
                                     input logic busy);
    item_t w;
    w = rand_fields();
    w.kind = k;
    w.dev_addr = dev;
    w.mem_addr = maddr;
    w.length = len;
    w.bus_busy = busy;
    return w;
  endfunction

  function automatic item_t mk_event(input logic [10:0] flags, input logic [7:0] data);
    item_t w;
    w = rand_fields();
    w.kind = KIND_EVENT;
    w.status_flags = flags;
    w.data_byte = data;
    return w;
  endfunction

  // Random status word that usually carries the flag the current phase waits for.
  function automatic item_t next_event();
    item_t       w;
    int unsigned awaited;
    w = rand_fields();
    w.kind = KIND_EVENT;
    case (seq_phase)
      RD_START, RD_RESTART, WR_START: awaited = FLAG_SB;
      RD_DEV_W, RD_DEV_R, WR_ADDR:    awaited = FLAG_ADDR;
      RD_DATA:                        awaited = FLAG_RXNE;
      WR_LAST:                        awaited = FLAG_BTF;
      default:                        awaited = FLAG_TXE;
    endcase
    w.status_flags[awaited] = ($urandom_range(0, 9) < 8);
    if (seq_phase == WR_ADDR && $urandom_range(0, 4) != 0) w.status_flags[FLAG_NACK] = 1'b0;
    return w;
  endfunction

  task automatic drive_word(input item_t w);
    result_t r;
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.kind         <= w.kind;
    in_if.dev_addr     <= w.dev_addr;
    in_if.mem_addr     <= w.mem_addr;
    in_if.length       <= w.length;
    in_if.bus_busy     <= w.bus_busy;
    in_if.status_flags <= w.status_flags;
    in_if.data_byte    <= w.data_byte;
    in_if.load_index   <= w.load_index;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = predict_step(w);
    expected_results.push_back(r);
    sent_words++;
  endtask

  task automatic send_word(input item_t w);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          in_if.valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    // Never let the block send a buffer entry that was never loaded.
    if (kind_e'(w.kind) == KIND_EVENT && seq_phase == WR_DATA && w.status_flags[FLAG_TXE] &&
        byte_cnt < xfer_len && !tx_known[byte_cnt[7:0]])
      drive_word(mk_load(byte_cnt[7:0], 8'($urandom)));
    drive_word(w);
  endtask

  task automatic finish_active();
    int unsigned pick;
    while (seq_phase != SEQ_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        send_word(mk_start(kind_e'($urandom_range(1, 2)), 8'($urandom), 11'($urandom),
                           9'($urandom), 1'($urandom)));
      else if (pick < 7)
        send_word(mk_load(8'($urandom_range(0, 63)), 8'($urandom)));
      else
        send_word(next_event());
    end
  endtask

  task automatic run_transaction(input kind_e k, input int unsigned len);
    finish_active();
    send_word(mk_start(k, 8'($urandom), 11'($urandom), 9'(len), 1'b0));
    finish_active();
  endtask

  task automatic test_directed_read();
    send_word(mk_event(11'h7FF, 8'hFF));
    send_word(mk_start(KIND_READ, 8'hFF, 11'h7FF, 9'd0, 1'b0));
    send_word(mk_event(SB_BIT, 8'h00));
    send_word(mk_event(11'h000, 8'h00));
    send_word(mk_event(ADDR_BIT, 8'h00));
    send_word(mk_event(TXE_BIT, 8'h00));
    send_word(mk_event(SB_BIT, 8'h00));
    send_word(mk_event(ADDR_BIT, 8'h00));
    send_word(mk_event(RXNE_BIT, 8'hFF));
  endtask

  task automatic test_refusals_and_polling();
    send_word(mk_start(KIND_READ, 8'hA0, 11'h000, 9'd4, 1'b1));
    send_word(mk_start(KIND_WRITE, 8'h00, 11'h000, 9'd0, 1'b0));
    send_word(mk_start(KIND_READ, 8'hA0, 11'h123, 9'd3, 1'b0));
    send_word(mk_event(SB_BIT, 8'h00));
    send_word(mk_event(NACK_BIT | ADDR_BIT, 8'h00));
    send_word(mk_event(SB_BIT, 8'h00));
    send_word(mk_event(ADDR_BIT, 8'h00));
    send_word(mk_event(TXE_BIT, 8'h00));
    send_word(mk_event(BTF_BIT, 8'h00));
  endtask

  task automatic test_directed_write();
    send_word(mk_load(8'd0, 8'hFF));
    send_word(mk_load(8'd1, 8'h00));
    send_word(mk_load(8'd255, 8'h5A));
    send_word(mk_start(KIND_WRITE, 8'hA6, 11'h555, 9'd2, 1'b0));
    send_word(mk_event(SB_BIT, 8'h00));
    send_word(mk_event(ADDR_BIT, 8'h00));
    send_word(mk_event(TXE_BIT, 8'h00));
    send_word(mk_event(TXE_BIT, 8'h00));
    send_word(mk_event(TXE_BIT, 8'h00));
    send_word(mk_event(BTF_BIT, 8'h00));
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_req++;
    run_transaction(KIND_READ, 12);
  endtask

  // Fills the remaining word budget with random traffic.
  task automatic test_random_mix();
    int unsigned pick;
    item_t       w;
    while (sent_words < ITEM_BUDGET) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) begin
          w = rand_fields();
          if ($urandom_range(0, 9) != 0) w.length = 9'($urandom_range(0, 15));
          send_word(w);
        end
      end else if (pick < 22) begin
        repeat ($urandom_range(1, 8)) send_word(mk_load(8'($urandom_range(0, 47)), 8'($urandom)));
      end else if (pick < 27) begin
        send_word(mk_start(kind_e'($urandom_range(1, 2)), 8'($urandom), 11'($urandom),
                           9'($urandom), 1'b1));
      end else begin
        run_transaction(kind_e'($urandom_range(1, 2)),
                        ($urandom_range(0, 6) == 0) ? $urandom_range(13, 48)
                                                    : $urandom_range(0, 12));
      end
    end
  endtask

  // A read of 256 to 264 bytes runs the read index to its end and, past 256, wraps it.
  task automatic test_buffer_wrap();
    sender_gaps = 1'b1;
    run_transaction(KIND_READ, 256 + $urandom_range(0, 8));
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result word with nothing expected", $time);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("write_valid", want.write_valid, out_if.write_valid);
        check_field("write_byte", want.write_byte, out_if.write_byte);
        check_field("start_cond", want.start_cond, out_if.start_cond);
        check_field("stop_cond", want.stop_cond, out_if.stop_cond);
        check_field("ack_level", want.ack_level, out_if.ack_level);
        check_field("clear_nack", want.clear_nack, out_if.clear_nack);
        check_field("read_valid", want.read_valid, out_if.read_valid);
        check_field("read_byte", want.read_byte, out_if.read_byte);
        check_field("read_index", want.read_index, out_if.read_index);
        check_field("done_res", want.done_res, out_if.done_res);
        check_field("start_status", want.start_status, out_if.start_status);
        check_field("active", want.active, out_if.active);
      end
    end
  end

  // Receiver: switches between stall patterns and honors long hold-off requests.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.dev_addr = '0;
    in_if.mem_addr = '0;
    in_if.length = '0;
    in_if.bus_busy = 1'b0;
    in_if.status_flags = '0;
    in_if.data_byte = '0;
    in_if.load_index = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_read();
    test_refusals_and_polling();
    test_directed_write();
    test_backpressure();
    test_buffer_wrap();
    test_random_mix();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d expected result words never arrived", $time,
               expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/i2cee_pkg.sv
design/i2cee_in_if.sv
design/i2cee_out_if.sv
design/i2cee_ram.sv
design/i2cee_core.sv
design/i2c_eeprom_transfer_sequencer.sv
tb/sv/tb_top.sv
